/* hw/rtl/dab_rd_pkg.sv */
// Shared types and register codes for the dab rectangle difference unit.
`default_nettype none
package dab_rd_pkg;

	localparam int COORD_W = 15;
	localparam int NUM_RECT = 4;

	// Configuration register indexes
	localparam logic [1:0] REG_SURFACE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SURFACE_HEIGHT = 2'd1;

	typedef struct packed {
		logic [COORD_W-1:0] bottom;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] left;
	} rect_t;

	// One classified dab: candidate stripes and which of them are emitted.
	// Bit 0 above, bit 1 below, bit 2 left, bit 3 right (or whole rect in slot 0).
	typedef struct packed {
		rect_t [NUM_RECT-1:0] rect;
		logic  [NUM_RECT-1:0] mask;
	} entry_t;

endpackage
`default_nettype wire

/* hw/rtl/dab_rd_queue.sv */
// Small first-in first-out queue between the classifier and the emitter.
`default_nettype none
module dab_rd_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  not_full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  not_empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign not_full  = (count_q != CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/dab_rd_front.sv */
// Front end: surface registers, clipping stage and classification against the previous dab.
`default_nettype none
module dab_rd_front #(
	parameter int MAX_SURFACE_SIZE = 16384
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_valid,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [14:0]    cfg_data,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic           kind,
	input  wire logic [15:0]    dab_left,
	input  wire logic [15:0]    dab_top,
	input  wire logic [13:0]    dab_width,
	input  wire logic [13:0]    dab_height,
	output logic                push,
	output dab_rd_pkg::entry_t  push_entry,
	input  wire logic           q_not_full
);
	import dab_rd_pkg::*;

	localparam logic [17:0] MAX_SZ = 18'(MAX_SURFACE_SIZE);
	localparam logic [COORD_W-1:0] SIZE_RESET =
		COORD_W'((MAX_SURFACE_SIZE < 1024) ? MAX_SURFACE_SIZE : 1024);

	logic [COORD_W-1:0] surf_w_q, surf_h_q, cfg_clamped;

	assign cfg_clamped = ({3'b000, cfg_data} > MAX_SZ) ? MAX_SZ[COORD_W-1:0] : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surf_w_q <= SIZE_RESET;
			surf_h_q <= SIZE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SURFACE_WIDTH:  surf_w_q <= cfg_clamped;
				REG_SURFACE_HEIGHT: surf_h_q <= cfg_clamped;
				default: ;
			endcase
		end
	end

	// Clip stage
	logic signed [17:0] left_x, top_x, right_x, bottom_x, sw_x, sh_x;
	logic signed [17:0] l_c, t_c, r_c, b_c;
	logic nonempty;

	always_comb begin
		left_x   = {{2{dab_left[15]}}, dab_left};
		top_x    = {{2{dab_top[15]}}, dab_top};
		right_x  = left_x + $signed({4'b0000, dab_width});
		bottom_x = top_x + $signed({4'b0000, dab_height});
		sw_x     = $signed({3'b000, surf_w_q});
		sh_x     = $signed({3'b000, surf_h_q});
		l_c      = left_x[17] ? '0 : left_x;
		t_c      = top_x[17] ? '0 : top_x;
		r_c      = (right_x > sw_x) ? sw_x : right_x;
		b_c      = (bottom_x > sh_x) ? sh_x : bottom_x;
		nonempty = (l_c < r_c) && (t_c < b_c);
	end

	logic  v_s1, kind_s1, ne_s1;
	rect_t clip_s1;
	logic  done;

	assign in_ready = !v_s1 || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1        <= kind;
			ne_s1          <= nonempty;
			clip_s1.left   <= l_c[COORD_W-1:0];
			clip_s1.top    <= t_c[COORD_W-1:0];
			clip_s1.right  <= r_c[COORD_W-1:0];
			clip_s1.bottom <= b_c[COORD_W-1:0];
		end
	end

	// Classify against the stored rectangle
	rect_t prev_q;
	logic  overlap;
	logic [COORD_W-1:0] band_top, band_bot;
	entry_t ent;

	always_comb begin
		overlap = (clip_s1.top < prev_q.bottom) && (clip_s1.bottom > prev_q.top) &&
			(clip_s1.left < prev_q.right) && (clip_s1.right > prev_q.left);
		band_top = (clip_s1.top < prev_q.top) ? prev_q.top : clip_s1.top;
		band_bot = (clip_s1.bottom > prev_q.bottom) ? prev_q.bottom : clip_s1.bottom;
		ent = '0;
		if (overlap) begin
			ent.mask[0] = clip_s1.top < prev_q.top;
			ent.mask[1] = clip_s1.bottom > prev_q.bottom;
			ent.mask[2] = clip_s1.left < prev_q.left;
			ent.mask[3] = clip_s1.right > prev_q.right;
			ent.rect[0] = '{bottom: prev_q.top, right: clip_s1.right,
				top: clip_s1.top, left: clip_s1.left};
			ent.rect[1] = '{bottom: clip_s1.bottom, right: clip_s1.right,
				top: prev_q.bottom, left: clip_s1.left};
			ent.rect[2] = '{bottom: band_bot, right: prev_q.left,
				top: band_top, left: clip_s1.left};
			ent.rect[3] = '{bottom: band_bot, right: clip_s1.right,
				top: band_top, left: prev_q.right};
		end else begin
			ent.mask    = 4'b0001;
			ent.rect[0] = clip_s1;
		end
	end

	logic need_push;
	assign need_push  = kind_s1 && ne_s1 && (ent.mask != '0);
	assign done       = v_s1 && (!need_push || q_not_full);
	assign push       = v_s1 && need_push && q_not_full;
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (done) begin
			if (!kind_s1) begin
				prev_q <= '0;
			end else if (ne_s1) begin
				prev_q <= clip_s1;
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/dab_rd_back.sv */
// Back end: serialises the queued stripes of each dab into output beats.
`default_nettype none
module dab_rd_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_not_empty,
	input  wire dab_rd_pkg::entry_t  q_entry,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output dab_rd_pkg::rect_t        out_rect,
	output logic                     out_last
);
	import dab_rd_pkg::*;

	logic [NUM_RECT-1:0] mask_q;
	rect_t [NUM_RECT-1:0] rect_q;
	logic [NUM_RECT-1:0] pick, remain;
	logic [1:0] sel;
	logic work_v, adv, is_last;
	logic out_v_q;

	always_comb begin
		sel = 2'd0;
		for (int i = NUM_RECT - 1; i >= 0; i--) begin
			if (mask_q[i]) sel = 2'(i);
		end
		pick   = NUM_RECT'(1) << sel;
		remain = mask_q & ~pick;
	end

	assign work_v  = (mask_q != '0);
	assign adv     = work_v && (!out_v_q || out_ready);
	assign is_last = (remain == '0);
	assign pop     = q_not_empty && (!work_v || (adv && is_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				mask_q <= q_entry.mask;
			end else if (adv) begin
				mask_q <= remain;
			end
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rect_q <= q_entry.rect;
		end
		if (adv) begin
			out_rect <= rect_q[sel];
			out_last <= is_last;
		end
	end

	assign out_valid = out_v_q;

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (q_entry.mask != '0))
		else $error("empty stripe set taken from queue");

	a_pick_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> $onehot(pick) && ((pick & mask_q) != '0))
		else $error("selected stripe not pending");

	a_rect_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_rect.right > out_rect.left) && (out_rect.bottom > out_rect.top))
		else $error("empty rectangle on output");

endmodule
`default_nettype wire

/* hw/rtl/dab_rect_difference_unit.sv */
// Top level of the dab rectangle difference unit: clip, subtract previous dab, emit stripes.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | tdata dab rect, tuser kind
//  m_axis   | out       | m_axis_tvalid/tready    | tdata saved rect, tlast last stripe of dab
//  cfg      | in        | cfg_valid/cfg_ready     | cfg_index register, cfg_data value
//
// Flow: a dab passes a clip stage and a classify stage, then waits in a two-entry
// queue; the emitter sends one stripe per cycle while m_axis_tready is held high, one to
// four stripes per dab, and a dab or stroke start with no stripes never enters the queue.
// Throughput is set by the single output register of the emitter.
// Reset: surface sizes return to 1024 (or MAX_SURFACE_SIZE if smaller), previous rect to zero.
// Stalls: output back-pressure fills the queue before the input stalls; cfg_ready is always high.
`default_nettype none
module dab_rect_difference_unit #(
	parameter int MAX_SURFACE_SIZE = 16384
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [14:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [15:0] dab_left, [31:16] dab_top, [45:32] dab_width, [59:46] dab_height, rest zero
	input  wire logic [63:0] s_axis_tdata,
	// [0] kind
	input  wire logic        s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [14:0] rect_left, [29:15] rect_top, [44:30] rect_right, [59:45] rect_bottom, rest zero
	output logic [63:0]      m_axis_tdata,
	output logic             m_axis_tlast
);
	import dab_rd_pkg::*;

	logic   push, q_not_full, pop, q_not_empty;
	entry_t push_entry, q_entry;
	rect_t  out_rect;

	// Registers take a write every cycle; configure only while idle.
	assign cfg_ready = 1'b1;

	dab_rd_front #(
		.MAX_SURFACE_SIZE(MAX_SURFACE_SIZE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.kind       (s_axis_tuser),
		.dab_left   (s_axis_tdata[15:0]),
		.dab_top    (s_axis_tdata[31:16]),
		.dab_width  (s_axis_tdata[45:32]),
		.dab_height (s_axis_tdata[59:46]),
		.push       (push),
		.push_entry (push_entry),
		.q_not_full (q_not_full)
	);

	// Decouple classification from emission
	dab_rd_queue #(
		.WIDTH($bits(entry_t)),
		.DEPTH(2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.not_full  (q_not_full),
		.pop       (pop),
		.pop_data  (q_entry),
		.not_empty (q_not_empty)
	);

	dab_rd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_entry     (q_entry),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_rect    (out_rect),
		.out_last    (m_axis_tlast)
	);

	// Pack the beat, upper bits held at zero
	assign m_axis_tdata = {4'b0000, out_rect.bottom, out_rect.right, out_rect.top, out_rect.left};

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the dab rectangle difference unit.
module tb;
	import dab_rd_pkg::*;

	// Input kinds carried on s_axis_tuser
	localparam logic KIND_STROKE_START = 1'b0;
	localparam logic KIND_DAB          = 1'b1;

	// Register indexes the block does not decode; writes to them must be ignored
	localparam logic [1:0] REG_SPARE_2 = 2'd2;
	localparam logic [1:0] REG_SPARE_3 = 2'd3;

	localparam int SURFACE_LIMIT = 16384;	// MAX_SURFACE_SIZE of the instance
	localparam int SETTLE_CYCLES = 12;		// clip, classify, queue and emitter, with margin
	localparam int DRAIN_LIMIT   = 50000;
	localparam int MAX_REPORTS   = 10;

	// One saved rectangle as it should leave the master side
	typedef struct {
		rect_t area;
		logic  last;
	} stripe_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic [1:0]  cfg_index     = '0;
	logic [14:0] cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic [63:0] s_axis_tdata  = '0;	// [15:0] left, [31:16] top, [45:32] width, [59:46] height
	logic        s_axis_tuser  = 1'b0;	// [0] kind
	logic        m_axis_tready = 1'b0;
	wire         cfg_ready;
	wire         s_axis_tready;
	wire         m_axis_tvalid;
	wire  [63:0] m_axis_tdata;		// [14:0] left, [29:15] top, [44:30] right, [59:45] bottom
	wire         m_axis_tlast;

	// Mirror of the block: surface limits and the previous clipped dab
	int surf_w = 1024;
	int surf_h = 1024;
	int prev_l = 0;
	int prev_t = 0;
	int prev_r = 0;
	int prev_b = 0;

	stripe_t expected_stripes[$];

	int error_count     = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct  = 0;
	int hold_off        = 0;	// cycles the receiver still has to hold tready low

	always #5 clk = ~clk;

	dab_rect_difference_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Count every failure; print only the first few so the log stays short
	function automatic void note_error(string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: %s", $time, msg);
	endfunction

	function automatic void check_field(string what, int want, int got);
		if (want != got)
			note_error($sformatf("%s mismatch: expected %0d, got %0d", what, want, got));
	endfunction

	function automatic int clamp_surface(logic [14:0] v);
		return (int'(v) > SURFACE_LIMIT) ? SURFACE_LIMIT : int'(v);
	endfunction

	function automatic void add_stripe(int l, int t, int r, int b);
		stripe_t s;
		s.area.left   = l[14:0];
		s.area.top    = t[14:0];
		s.area.right  = r[14:0];
		s.area.bottom = b[14:0];
		s.last        = 1'b0;
		expected_stripes.push_back(s);
	endfunction

	// Clip one dab, subtract the previous clipped dab and queue the stripes left over
	function automatic void predict_stripes(logic kind, logic [15:0] l16, logic [15:0] t16,
			logic [13:0] w, logic [13:0] h);
		int l, t, r, b;
		int band_t, band_b;
		int n_before;
		if (kind == KIND_STROKE_START) begin
			prev_l = 0;
			prev_t = 0;
			prev_r = 0;
			prev_b = 0;
			return;
		end
		l = int'($signed(l16));
		t = int'($signed(t16));
		r = l + int'(w);
		b = t + int'(h);
		if (l < 0) l = 0;
		if (t < 0) t = 0;
		if (r > surf_w) r = surf_w;
		if (b > surf_h) b = surf_h;
		// An empty dab leaves the stored rectangle alone
		if (!(l < r && t < b))
			return;
		n_before = expected_stripes.size();
		if (t < prev_b && b > prev_t && l < prev_r && r > prev_l) begin
			band_t = t;
			band_b = b;
			if (t < prev_t) begin
				add_stripe(l, t, r, prev_t);
				band_t = prev_t;
			end
			if (b > prev_b) begin
				add_stripe(l, prev_b, r, b);
				band_b = prev_b;
			end
			if (l < prev_l)
				add_stripe(l, band_t, prev_l, band_b);
			if (r > prev_r)
				add_stripe(prev_r, band_t, r, band_b);
		end else begin
			add_stripe(l, t, r, b);
		end
		if (expected_stripes.size() > n_before)
			expected_stripes[expected_stripes.size() - 1].last = 1'b1;
		prev_l = l;
		prev_t = t;
		prev_r = r;
		prev_b = b;
	endfunction

	// Master side: check each beat against the oldest expected stripe, then choose
	// tready for the next cycle. A pending hold-off overrides the random stalls.
	always @(posedge clk) begin : stripe_sink
		stripe_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_stripes.size() == 0) begin
				note_error($sformatf("unexpected beat: tdata %h tlast %b",
					m_axis_tdata, m_axis_tlast));
			end else begin
				want = expected_stripes.pop_front();
				check_field("rect_left", want.area.left, m_axis_tdata[14:0]);
				check_field("rect_top", want.area.top, m_axis_tdata[29:15]);
				check_field("rect_right", want.area.right, m_axis_tdata[44:30]);
				check_field("rect_bottom", want.area.bottom, m_axis_tdata[59:45]);
				check_field("tdata padding", 0, m_axis_tdata[63:60]);
				check_field("last_of_run", want.last, m_axis_tlast);
			end
		end
		if (hold_off > 0) begin
			m_axis_tready <= 1'b0;
			hold_off--;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Offer one item on the slave side and predict its stripes once it is taken.
	// Called at a rising edge; returns at the edge that accepted the beat.
	task automatic send_item(logic kind, logic [15:0] l16, logic [15:0] t16,
			logic [13:0] w, logic [13:0] h);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {4'b0000, h, w, t16, l16};
		do @(posedge clk); while (!s_axis_tready);
		predict_stripes(kind, l16, t16, w, h);
	endtask

	// Drop tvalid, wait for every expected stripe, then let items with no
	// stripes clear the pipeline before anything else happens.
	task automatic wait_idle();
		int spent;
		spent = 0;
		s_axis_tvalid <= 1'b0;
		while (expected_stripes.size() != 0 && spent < DRAIN_LIMIT) begin
			@(posedge clk);
			spent++;
		end
		if (expected_stripes.size() != 0) begin
			note_error($sformatf("%0d expected stripes never arrived",
				expected_stripes.size()));
			expected_stripes.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [14:0] val);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SURFACE_WIDTH:  surf_w = clamp_surface(val);
			REG_SURFACE_HEIGHT: surf_h = clamp_surface(val);
			default: ;
		endcase
	endtask

	task automatic set_surface(logic [14:0] w, logic [14:0] h);
		write_reg(REG_SURFACE_WIDTH, w);
		write_reg(REG_SURFACE_HEIGHT, h);
	endtask

	task automatic set_idling(int sender_pct, int recv_pct);
		sender_idle_pct = sender_pct;
		recv_stall_pct  = recv_pct;
	endtask

	// Brush strokes: dabs wander a few pixels at a time so successive rectangles
	// overlap in every way, with stroke starts and full-range noise mixed in.
	task automatic run_strokes(int count);
		int x, y;
		int pick;
		x = $urandom_range(0, surf_w);
		y = $urandom_range(0, surf_h);
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				send_item(KIND_STROKE_START, 16'($urandom), 16'($urandom),
					14'($urandom), 14'($urandom));
				x = $urandom_range(0, surf_w);
				y = $urandom_range(0, surf_h);
			end else if (pick < 20) begin
				send_item(KIND_DAB, 16'($urandom), 16'($urandom),
					14'($urandom), 14'($urandom));
			end else begin
				x += int'($urandom_range(0, 10)) - 5;
				y += int'($urandom_range(0, 10)) - 5;
				if (x < -10 || x > surf_w + 10)
					x = $urandom_range(0, surf_w);
				if (y < -10 || y > surf_h + 10)
					y = $urandom_range(0, surf_h);
				send_item(KIND_DAB, 16'(x), 16'(y),
					14'($urandom_range(0, 14)), 14'($urandom_range(0, 14)));
			end
		end
	endtask

	// Reset surface of 1024 square: clipping, subtraction shapes and field extremes
	task automatic test_directed_default();
		send_item(KIND_STROKE_START, 16'($urandom), 16'($urandom),
			14'($urandom), 14'($urandom));
		send_item(KIND_DAB, -16'sd5, -16'sd5, 14'd20, 14'd20);		// clipped at left and top
		send_item(KIND_DAB, 16'd5, 16'd5, 14'd5, 14'd5);			// fully inside: nothing
		send_item(KIND_DAB, 16'd0, 16'd0, 14'd15, 14'd15);			// surrounds: four stripes
		send_item(KIND_DAB, 16'd20, 16'd20, 14'd10, 14'd10);		// disjoint: whole rect
		send_item(KIND_DAB, 16'd25, 16'd25, 14'd0, 14'd10);			// zero width
		send_item(KIND_DAB, 16'd25, 16'd25, 14'd10, 14'd0);			// zero height
		send_item(KIND_DAB, 16'h7FFF, 16'd0, 14'h3FFF, 14'd10);		// left beyond surface
		send_item(KIND_DAB, 16'h8000, 16'd0, 14'h3FFF, 14'd10);		// still left of zero
		send_item(KIND_DAB, 16'd0, 16'h8000, 14'd10, 14'h3FFF);
		send_item(KIND_DAB, 16'd0, 16'h7FFF, 14'd10, 14'h3FFF);
		send_item(KIND_DAB, 16'd1000, 16'd1000, 14'h3FFF, 14'h3FFF);	// clipped right, bottom
		send_item(KIND_STROKE_START, 16'hFFFF, 16'hFFFF, 14'h3FFF, 14'h3FFF);
		send_item(KIND_DAB, 16'd1000, 16'd1000, 14'd24, 14'd24);	// nothing excluded now
	endtask

	// Largest, saturated, smallest, spare and zero register values
	task automatic test_surface_registers();
		set_surface(15'd16384, 15'd16384);
		send_item(KIND_DAB, 16'd100, 16'd16000, 14'h3FFF, 14'h3FFF);
		set_surface(15'h7FFF, 15'h7FFF);							// saturates to the maximum
		send_item(KIND_DAB, 16'd16380, 16'd16380, 14'd100, 14'd100);
		set_surface(15'd1, 15'd1);
		send_item(KIND_DAB, 16'd0, 16'd0, 14'd5, 14'd5);
		send_item(KIND_DAB, -16'sd3, -16'sd3, 14'd4, 14'd4);
		write_reg(REG_SPARE_2, 15'd0);
		write_reg(REG_SPARE_3, 15'h7FFF);
		send_item(KIND_STROKE_START, 16'd0, 16'd0, 14'd0, 14'd0);
		send_item(KIND_DAB, 16'd0, 16'd0, 14'd3, 14'd3);
		set_surface(15'd0, 15'd0);									// every dab clips to empty
		send_item(KIND_DAB, 16'd0, 16'd0, 14'd10, 14'd10);
		send_item(KIND_STROKE_START, 16'($urandom), 16'($urandom),
			14'($urandom), 14'($urandom));
	endtask

	// Random strokes under each idling pattern and a few surface shapes
	task automatic test_random_phases();
		set_surface(15'd64, 15'd48);
		set_idling(0, 0);
		run_strokes(30);
		set_idling(53, 0);
		run_strokes(30);
		set_surface(15'd40, 15'd200);
		set_idling(0, 53);
		run_strokes(30);
		set_surface(15'd16384, 15'd16384);
		set_idling(19, 19);
		run_strokes(30);
	endtask

	// Hold the master side off long enough that the queue fills and the
	// slave side has to stall, while items keep coming back to back.
	task automatic test_backpressure();
		set_surface(15'd64, 15'd48);
		set_idling(0, 0);
		hold_off = 80;
		run_strokes(24);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_default();
		test_surface_registers();
		test_random_phases();
		test_backpressure();
		wait_idle();
		if (error_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// Watchdog well beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("tb: errors");
		$finish;
	end

endmodule
